// ===== hdl/ptfb_pkg.sv =====
// Package: shared types and constants of the photon tile frustum binning block.
`default_nettype none
package ptfb_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TEST  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_TILES  = 1'b1;

  localparam int SLOT_W = 20;
  localparam int TILE_OUT_W = 6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         tile_number;
    logic [1:0]         plane_number;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        photon_tag;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  hit_tile;
    logic [19:0] slot;
    logic [31:0] tag_out;
    logic        slot_saturated;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } normal_t;

  typedef struct packed {
    logic [30:0] effect_radius;
    logic [6:0]  tiles_in_use;
  } cfg_t;

  typedef struct packed {
    logic mul;
    logic prod;
  } eval_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/ptfb_in_if.sv =====
// Interface: input item channel.
`default_nettype none
interface ptfb_in_if;
  import ptfb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ptfb_out_if.sv =====
// Interface: result item channel.
`default_nettype none
interface ptfb_out_if;
  import ptfb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ptfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== hdl/ptfb_cfg.sv =====
// APB-style configuration registers: effect radius and tiles in use.
`default_nettype none
module ptfb_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  output ptfb_pkg::cfg_t    cfg
);
  import ptfb_pkg::*;

  logic [30:0] radius_r, radius_nxt;
  logic [6:0]  tiles_r, tiles_nxt;
  logic        wr;

  assign wr = psel && penable && pwrite;

  always_comb begin
    radius_nxt = radius_r;
    tiles_nxt  = tiles_r;
    if (wr) begin
      case (paddr[2])
        REG_RADIUS: radius_nxt = pwdata[30:0];
        REG_TILES:  tiles_nxt  = pwdata[6:0];
        default:    radius_nxt = radius_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 31'd65536;
      tiles_r  <= 7'd64;
    end else begin
      radius_r <= radius_nxt;
      tiles_r  <= tiles_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RADIUS: prdata = {1'b0, radius_r};
      REG_TILES:  prdata = {25'd0, tiles_r};
      default:    prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = '{effect_radius: radius_r, tiles_in_use: tiles_r};
endmodule
`default_nettype wire

// ===== hdl/ptfb_plane_eval.sv =====
// Plane test datapath: dot products, offset product and exact sphere rejection compare.
`default_nettype none
module ptfb_plane_eval (
  input  wire logic                clk,
  input  wire ptfb_pkg::eval_ctl_t ctl,
  input  wire ptfb_pkg::normal_t   normal,
  input  wire logic signed [31:0]  offset,
  input  wire logic signed [31:0]  pos_x,
  input  wire logic signed [31:0]  pos_y,
  input  wire logic signed [31:0]  pos_z,
  input  wire logic [30:0]         radius,
  output logic                     reject
);
  import ptfb_pkg::*;

  logic signed [15:0] nx, ny, nz;
  logic signed [47:0] px, py, pz;
  logic signed [31:0] xx, yy, zz;
  logic signed [49:0] np_r;
  logic signed [32:0] nn_r;
  logic signed [31:0] off_r;
  logic signed [50:0] a_r;
  logic signed [64:0] b_r;
  logic signed [64:0] b_prod;
  logic signed [64:0] a_scaled;

  assign nx = $signed(normal.x);
  assign ny = $signed(normal.y);
  assign nz = $signed(normal.z);
  assign px = nx * pos_x;
  assign py = ny * pos_y;
  assign pz = nz * pos_z;
  assign xx = nx * nx;
  assign yy = ny * ny;
  assign zz = nz * nz;
  assign b_prod = off_r * nn_r;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      np_r  <= 50'(px) + 50'(py) + 50'(pz);
      nn_r  <= 33'(xx) + 33'(yy) + 33'(zz);
      off_r <= offset;
    end
    if (ctl.prod) begin
      a_r <= np_r + $signed({6'd0, radius, 14'd0});
      b_r <= b_prod;
    end
  end

  // reject when 2^14*(n.p + 2^14*r) falls below d*(n.n), exact
  assign a_scaled = $signed({a_r, 14'd0});
  assign reject = a_scaled < b_r;
endmodule
`default_nettype wire

// ===== hdl/photon_tile_frustum_binning.sv =====
// A test item walks tiles in order; each plane passes S_PRD, S_PMUL, S_PPROD and S_PCMP,
//   and each hit tile adds S_CRD and S_CUPD. No new item is taken until the walk ends;
//   a stalled result side holds it. The single plane read port and the shared plane test
//   datapath serve one test item at a time.
// Load and clear items are handled in the idle state; results pass through a pending stage and output reg.
// Reset (synchronous, rst_n low) clears control state and marks all tile counters as zero;
//   the plane table holds no defined value until loaded.
`default_nettype none
module photon_tile_frustum_binning #(
  parameter int MAX_TILES       = 64,
  parameter int PLANES_PER_TILE = 4,
  parameter int COUNT_BITS      = 20
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  ptfb_in_if.sink           in_ch,
  ptfb_out_if.source        out_ch,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);
  import ptfb_pkg::*;

  localparam int TILE_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int PL_W   = (PLANES_PER_TILE > 1) ? $clog2(PLANES_PER_TILE) : 1;
  localparam int DEPTH  = MAX_TILES * PLANES_PER_TILE;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_PRD   = 8'b00000010,
    S_PMUL  = 8'b00000100,
    S_PPROD = 8'b00001000,
    S_PCMP  = 8'b00010000,
    S_CRD   = 8'b00100000,
    S_CUPD  = 8'b01000000,
    S_FLUSH = 8'b10000000
  } state_t;

  state_t              st_r, st_nxt;
  logic [TILE_W-1:0]   tile_r, tile_nxt;
  logic [PL_W-1:0]     pl_r, pl_nxt;
  logic [MAX_TILES-1:0] vld_r, vld_nxt;
  logic signed [31:0]  px_r, py_r, pz_r;
  logic [31:0]         tag_r;
  logic                pend_vld_r, pend_vld_nxt;
  logic [5:0]          pend_tile_r;
  logic [19:0]         pend_slot_r;
  logic                pend_sat_r;
  logic                out_vld_r, out_vld_nxt;
  out_item_t           out_r;
  logic                out_load;
  logic                out_last;
  logic                pend_load;

  cfg_t                cfg;
  logic [6:0]          ntiles, ntiles_m1, tile_ext;
  logic                accept, out_free, last_tile, last_plane;

  logic                plane_we;
  logic [AW-1:0]       plane_waddr, plane_raddr;
  logic [47:0]         normal_rd;
  logic [31:0]         offset_rd;
  eval_ctl_t           ectl;
  logic                reject;

  logic                cnt_we;
  logic [COUNT_BITS-1:0] cnt_rd, cnt_cur, cnt_new;
  logic                cnt_sat;
  logic [SLOT_W+COUNT_BITS-1:0] slot_ext;

  ptfb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign ntiles    = (cfg.tiles_in_use > 7'(MAX_TILES)) ? 7'(MAX_TILES) : cfg.tiles_in_use;
  assign ntiles_m1 = ntiles - 7'd1;
  assign tile_ext  = 7'(tile_r);
  assign last_tile = (tile_ext == ntiles_m1);
  assign last_plane = (pl_r == PL_W'(PLANES_PER_TILE - 1));

  assign in_ch.ready = (st_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_vld_r || out_ch.ready;

  assign plane_we = accept && (in_ch.data.cmd == CMD_LOAD)
                 && (7'(in_ch.data.tile_number) < 7'(MAX_TILES))
                 && (3'(in_ch.data.plane_number) < 3'(PLANES_PER_TILE));
  assign plane_waddr = AW'(int'(in_ch.data.tile_number) * PLANES_PER_TILE
                         + int'(in_ch.data.plane_number));
  assign plane_raddr = AW'(int'(tile_r) * PLANES_PER_TILE + int'(pl_r));

  ptfb_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_normal_store (
    .clk   (clk),
    .we    (plane_we),
    .waddr (plane_waddr),
    .wdata ({in_ch.data.normal_z, in_ch.data.normal_y, in_ch.data.normal_x}),
    .raddr (plane_raddr),
    .rdata (normal_rd)
  );

  ptfb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_offset_store (
    .clk   (clk),
    .we    (plane_we),
    .waddr (plane_waddr),
    .wdata (in_ch.data.plane_offset),
    .raddr (plane_raddr),
    .rdata (offset_rd)
  );

  assign ectl = '{mul: (st_r == S_PMUL), prod: (st_r == S_PPROD)};

  ptfb_plane_eval u_eval (
    .clk    (clk),
    .ctl    (ectl),
    .normal (normal_t'(normal_rd)),
    .offset ($signed(offset_rd)),
    .pos_x  (px_r),
    .pos_y  (py_r),
    .pos_z  (pz_r),
    .radius (cfg.effect_radius),
    .reject (reject)
  );

  ptfb_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_TILES)) u_tile_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (tile_r),
    .wdata (cnt_new),
    .raddr (tile_r),
    .rdata (cnt_rd)
  );

  // a counter not written since the last clear reads as zero
  assign cnt_cur  = vld_r[tile_r] ? cnt_rd : '0;
  assign cnt_sat  = (cnt_cur == CNT_MAX);
  assign cnt_new  = cnt_sat ? cnt_cur : cnt_cur + 1'b1;
  assign slot_ext = {{SLOT_W{1'b0}}, cnt_cur};

  always_comb begin
    st_nxt       = st_r;
    tile_nxt     = tile_r;
    pl_nxt       = pl_r;
    vld_nxt      = vld_r;
    pend_vld_nxt = pend_vld_r;
    pend_load    = 1'b0;
    out_load     = 1'b0;
    out_last     = 1'b0;
    cnt_we       = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.data.cmd)
            CMD_CLEAR: vld_nxt = '0;
            CMD_TEST: begin
              tile_nxt = '0;
              pl_nxt   = '0;
              if (ntiles != 7'd0) begin
                st_nxt = S_PRD;
              end
            end
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_PRD:   st_nxt = S_PMUL;
      S_PMUL:  st_nxt = S_PPROD;
      S_PPROD: st_nxt = S_PCMP;
      S_PCMP: begin
        if (reject) begin
          pl_nxt = '0;
          if (last_tile) begin
            st_nxt = S_FLUSH;
          end else begin
            tile_nxt = tile_r + 1'b1;
            st_nxt   = S_PRD;
          end
        end else if (last_plane) begin
          st_nxt = S_CRD;
        end else begin
          pl_nxt = pl_r + 1'b1;
          st_nxt = S_PRD;
        end
      end
      S_CRD: st_nxt = S_CUPD;
      S_CUPD: begin
        // hold until the previous hit can move to the output register
        if (!pend_vld_r || out_free) begin
          cnt_we          = 1'b1;
          vld_nxt[tile_r] = 1'b1;
          out_load        = pend_vld_r;
          pend_load       = 1'b1;
          pend_vld_nxt    = 1'b1;
          pl_nxt          = '0;
          if (last_tile) begin
            st_nxt = S_FLUSH;
          end else begin
            tile_nxt = tile_r + 1'b1;
            st_nxt   = S_PRD;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_vld_r) begin
          st_nxt = S_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_last     = 1'b1;
          pend_vld_nxt = 1'b0;
          st_nxt       = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      vld_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      vld_r      <= vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tile_r <= tile_nxt;
    pl_r   <= pl_nxt;
    if (accept && (in_ch.data.cmd == CMD_TEST)) begin
      px_r  <= in_ch.data.pos_x;
      py_r  <= in_ch.data.pos_y;
      pz_r  <= in_ch.data.pos_z;
      tag_r <= in_ch.data.photon_tag;
    end
    if (pend_load) begin
      pend_tile_r <= 6'(tile_r);
      pend_slot_r <= slot_ext[SLOT_W-1:0];
      pend_sat_r  <= cnt_sat;
    end
    if (out_load) begin
      out_r.hit_tile       <= pend_tile_r;
      out_r.slot           <= pend_slot_r;
      out_r.tag_out        <= tag_r;
      out_r.slot_saturated <= pend_sat_r;
      out_r.last           <= out_last;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

`ifndef ASSERT_OFF
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !pend_vld_r)
    else $error("pending hit left behind on return to idle");

  a_tile_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE && st_r != S_FLUSH) |-> (tile_ext < ntiles))
    else $error("tile index beyond tiles in use");

  a_test_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.cmd == CMD_TEST && ntiles != 7'd0) |=> (st_r == S_PRD))
    else $error("test item did not start the tile walk");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result overwritten before it was taken");
`endif
endmodule
`default_nettype wire
